### design/lsg_pkg.sv
// Package for the line segment guidance field: widths, register codes and
// the word types shared by the pipeline modules. No dependencies.
`timescale 1ns / 1ps

package lsg_pkg;

   // fixed formats
   localparam int COORD_BITS    = 16;
   localparam int COORD_FRAC    = 8;
   localparam int DIR_FRAC_BITS = 14;
   localparam int DIR_BITS      = DIR_FRAC_BITS + 2;
   localparam int GAIN_BITS     = 16;
   localparam int GAIN_FRAC     = 8;
   localparam int EXT_BITS      = 16;   // seg_length, half_width
   localparam int GUIDE_BITS    = 32;

   // datapath widths
   localparam int E_BITS   = COORD_BITS + 1;
   localparam int A_BITS   = E_BITS + DIR_BITS + 1;
   localparam int AD_BITS  = A_BITS + DIR_BITS;
   localparam int QF_BITS  = AD_BITS + 1;
   localparam int Q_BITS   = QF_BITS - DIR_FRAC_BITS;
   localparam int DD_BITS  = 2 * DIR_BITS;
   localparam int LD_BITS  = EXT_BITS + DD_BITS;
   localparam int AS_BITS  = A_BITS + DIR_FRAC_BITS + 1;
   localparam int S2_BITS  = ((AS_BITS > LD_BITS) ? AS_BITS : LD_BITS) + 1;
   localparam int GQ_BITS  = Q_BITS + GAIN_BITS + 1;
   localparam int GSH      = GAIN_FRAC + COORD_FRAC;
   localparam int GR_BITS  = GQ_BITS - GSH;
   localparam int GS_BITS  = (GR_BITS + 1 > GUIDE_BITS + 1) ? GR_BITS + 1 : GUIDE_BITS + 1;
   localparam int WQ_BITS  = EXT_BITS + DIR_FRAC_BITS;
   localparam int AQ_BITS  = (Q_BITS > WQ_BITS) ? Q_BITS : WQ_BITS;
   localparam int SQ_BITS  = 2 * WQ_BITS;
   localparam int D2_BITS  = SQ_BITS + 1;

   localparam int CSR_DATA_BITS_0 = (COORD_BITS > DIR_BITS) ? COORD_BITS : DIR_BITS;
   localparam int CSR_DATA_BITS   = (CSR_DATA_BITS_0 > EXT_BITS) ? CSR_DATA_BITS_0 : EXT_BITS;
   localparam int CSR_INDEX_BITS  = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ORIGIN_X   = 3'd0,
      CSR_ORIGIN_Y   = 3'd1,
      CSR_DIR_X      = 3'd2,
      CSR_DIR_Y      = 3'd3,
      CSR_GAIN       = 3'd4,
      CSR_SEG_LENGTH = 3'd5,
      CSR_HALF_WIDTH = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
   } req_type;

   typedef struct packed {
      logic signed [GUIDE_BITS-1:0] guide_x;
      logic signed [GUIDE_BITS-1:0] guide_y;
      logic                         in_range;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] origin_x;
      logic signed [COORD_BITS-1:0] origin_y;
      logic signed [DIR_BITS-1:0]   dir_x;
      logic signed [DIR_BITS-1:0]   dir_y;
      logic [GAIN_BITS-1:0]         gain;
      logic [EXT_BITS-1:0]          seg_length;
      logic [EXT_BITS-1:0]          half_width;
   } cfg_type;

   // front half -> back half
   typedef struct packed {
      logic                     valid;
      logic signed [Q_BITS-1:0] qx;
      logic signed [Q_BITS-1:0] qy;
      logic                     along_ok;
   } front_type;

endpackage

### design/lsg_front.sv
// Front half of the guidance pipeline: offset from origin, projection on the
// direction, rounded perpendicular offset and the along-track test. Uses lsg_pkg.
`timescale 1ns / 1ps

module lsg_front import lsg_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      in_valid,
   input  req_type   in_data,
   output front_type out
);

   // stage 1: E = O - P, D.D
   logic                     s1_valid_ff, s1_valid_in;
   logic signed [E_BITS-1:0] s1_ex_ff, s1_ex_in, s1_ey_ff, s1_ey_in;
   logic [DD_BITS-1:0]       s1_dd_ff, s1_dd_in;
   logic signed [DD_BITS-1:0] dxx, dyy;

   // stage 2: A = E.D, len * D.D
   logic                     s2_valid_ff;
   logic signed [E_BITS-1:0] s2_ex_ff, s2_ey_ff;
   logic signed [A_BITS-1:0] s2_a_ff, s2_a_in;
   logic [LD_BITS-1:0]       s2_ld_ff, s2_ld_in;
   logic signed [E_BITS+DIR_BITS-1:0] pxd, pyd;

   // stage 3: A*D, along-track sum
   logic                      s3_valid_ff;
   logic signed [E_BITS-1:0]  s3_ex_ff, s3_ey_ff;
   logic signed [AD_BITS-1:0] s3_adx_ff, s3_adx_in, s3_ady_ff, s3_ady_in;
   logic signed [S2_BITS-1:0] s3_s2_ff, s3_s2_in;

   // stage 4: rounded Q, along-track compare
   front_type                 s4_ff, s4_in;
   logic signed [QF_BITS-1:0] qfx, qfy;
   logic [S2_BITS-1:0]        s2_abs, s2_lim;

   always_comb begin
      s1_valid_in = in_valid;
      s1_ex_in    = E_BITS'(cfg.origin_x) - E_BITS'(in_data.pos_x);
      s1_ey_in    = E_BITS'(cfg.origin_y) - E_BITS'(in_data.pos_y);
      dxx         = cfg.dir_x * cfg.dir_x;
      dyy         = cfg.dir_y * cfg.dir_y;
      s1_dd_in    = $unsigned(dxx) + $unsigned(dyy);
   end

   always_comb begin
      pxd      = s1_ex_ff * cfg.dir_x;
      pyd      = s1_ey_ff * cfg.dir_y;
      s2_a_in  = A_BITS'(pxd) + A_BITS'(pyd);
      s2_ld_in = cfg.seg_length * s1_dd_ff;
   end

   always_comb begin
      s3_adx_in = s2_a_ff * cfg.dir_x;
      s3_ady_in = s2_a_ff * cfg.dir_y;
      s3_s2_in  = (S2_BITS'(s2_a_ff) <<< (DIR_FRAC_BITS + 1)) + $signed(S2_BITS'(s2_ld_ff));
   end

   always_comb begin
      // Q in 2^-(8+2F), rounded half up to 2^-(8+F)
      qfx = (QF_BITS'(s3_ex_ff) <<< (2 * DIR_FRAC_BITS)) - QF_BITS'(s3_adx_ff)
            + (QF_BITS'(1) <<< (DIR_FRAC_BITS - 1));
      qfy = (QF_BITS'(s3_ey_ff) <<< (2 * DIR_FRAC_BITS)) - QF_BITS'(s3_ady_ff)
            + (QF_BITS'(1) <<< (DIR_FRAC_BITS - 1));
      s2_abs = s3_s2_ff[S2_BITS-1] ? $unsigned(-s3_s2_ff) : $unsigned(s3_s2_ff);
      s2_lim = S2_BITS'(cfg.seg_length) << (2 * DIR_FRAC_BITS);
      s4_in.valid    = s3_valid_ff;
      s4_in.qx       = qfx[QF_BITS-1:DIR_FRAC_BITS];
      s4_in.qy       = qfy[QF_BITS-1:DIR_FRAC_BITS];
      s4_in.along_ok = (s2_abs <= s2_lim);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_ff.valid <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_ff       <= s4_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ex_ff  <= s1_ex_in;
      s1_ey_ff  <= s1_ey_in;
      s1_dd_ff  <= s1_dd_in;
      s2_ex_ff  <= s1_ex_ff;
      s2_ey_ff  <= s1_ey_ff;
      s2_a_ff   <= s2_a_in;
      s2_ld_ff  <= s2_ld_in;
      s3_ex_ff  <= s2_ex_ff;
      s3_ey_ff  <= s2_ey_ff;
      s3_adx_ff <= s3_adx_in;
      s3_ady_ff <= s3_ady_in;
      s3_s2_ff  <= s3_s2_in;
   end

   assign out = s4_ff;

endmodule

### design/lsg_back.sv
// Back half of the guidance pipeline: gain on the offset, saturated guidance
// vector and the squared distance test. Uses lsg_pkg.
`timescale 1ns / 1ps

module lsg_back import lsg_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  front_type in,
   output logic      rsp_valid,
   output rsp_type   rsp_data
);

   // stage 5: gain * Q, |Q| and the per-axis gate
   logic                      s5_valid_ff;
   logic signed [GQ_BITS-1:0] s5_gqx_ff, s5_gqx_in, s5_gqy_ff, s5_gqy_in;
   logic [WQ_BITS-1:0]        s5_aqx_ff, s5_aqy_ff;
   logic                      s5_gate_ff, s5_gate_in, s5_along_ff;
   logic [AQ_BITS-1:0]        aqx, aqy, wq;

   // stage 6: guidance vector, squares
   logic                         s6_valid_ff;
   logic signed [GUIDE_BITS-1:0] s6_gx_ff, s6_gx_in, s6_gy_ff, s6_gy_in;
   logic [SQ_BITS-1:0]           s6_sqx_ff, s6_sqy_ff;
   logic [2*EXT_BITS-1:0]        s6_w2_ff;
   logic                         s6_gate_ff, s6_along_ff;
   logic signed [GQ_BITS-1:0]    gqx_r, gqy_r;
   logic signed [GR_BITS-1:0]    grx, gry;
   logic signed [GS_BITS-1:0]    gsx, gsy;

   // stage 7: distance compare, result word
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic [D2_BITS-1:0]   d2, w2;

   localparam logic signed [GS_BITS-1:0] GUIDE_MAX = GS_BITS'(32'sh7fffffff);
   localparam logic signed [GS_BITS-1:0] GUIDE_MIN = GS_BITS'(32'sh80000000);

   always_comb begin
      s5_gqx_in = $signed({1'b0, cfg.gain}) * in.qx;
      s5_gqy_in = $signed({1'b0, cfg.gain}) * in.qy;
      aqx = AQ_BITS'(in.qx[Q_BITS-1] ? $unsigned(-in.qx) : $unsigned(in.qx));
      aqy = AQ_BITS'(in.qy[Q_BITS-1] ? $unsigned(-in.qy) : $unsigned(in.qy));
      wq  = AQ_BITS'({cfg.half_width, {DIR_FRAC_BITS{1'b0}}});
      s5_gate_in = (aqx <= wq) && (aqy <= wq);
   end

   always_comb begin
      gqx_r = s5_gqx_ff + (GQ_BITS'(1) <<< (GSH - 1));
      gqy_r = s5_gqy_ff + (GQ_BITS'(1) <<< (GSH - 1));
      grx   = gqx_r[GQ_BITS-1:GSH];
      gry   = gqy_r[GQ_BITS-1:GSH];
      gsx   = GS_BITS'(grx) + GS_BITS'(cfg.dir_x);
      gsy   = GS_BITS'(gry) + GS_BITS'(cfg.dir_y);
      if (gsx > GUIDE_MAX)      s6_gx_in = GUIDE_MAX[GUIDE_BITS-1:0];
      else if (gsx < GUIDE_MIN) s6_gx_in = GUIDE_MIN[GUIDE_BITS-1:0];
      else                      s6_gx_in = gsx[GUIDE_BITS-1:0];
      if (gsy > GUIDE_MAX)      s6_gy_in = GUIDE_MAX[GUIDE_BITS-1:0];
      else if (gsy < GUIDE_MIN) s6_gy_in = GUIDE_MIN[GUIDE_BITS-1:0];
      else                      s6_gy_in = gsy[GUIDE_BITS-1:0];
   end

   always_comb begin
      // squares are only meaningful when the per-axis gate passed
      d2 = D2_BITS'(s6_sqx_ff) + D2_BITS'(s6_sqy_ff);
      w2 = D2_BITS'(s6_w2_ff) << (2 * DIR_FRAC_BITS);
      rsp_data_in.guide_x  = s6_gx_ff;
      rsp_data_in.guide_y  = s6_gy_ff;
      rsp_data_in.in_range = s6_gate_ff && s6_along_ff && (d2 <= w2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff  <= in.valid;
         s6_valid_ff  <= s5_valid_ff;
         rsp_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s5_gqx_ff   <= s5_gqx_in;
      s5_gqy_ff   <= s5_gqy_in;
      s5_aqx_ff   <= WQ_BITS'(aqx);
      s5_aqy_ff   <= WQ_BITS'(aqy);
      s5_gate_ff  <= s5_gate_in;
      s5_along_ff <= in.along_ok;
      s6_gx_ff    <= s6_gx_in;
      s6_gy_ff    <= s6_gy_in;
      s6_sqx_ff   <= s5_aqx_ff * s5_aqx_ff;
      s6_sqy_ff   <= s5_aqy_ff * s5_aqy_ff;
      s6_w2_ff    <= cfg.half_width * cfg.half_width;
      s6_gate_ff  <= s5_gate_ff;
      s6_along_ff <= s5_along_ff;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_word_carried : assert property (@(posedge clock) disable iff (reset)
      s6_valid_ff |=> rsp_valid_ff)
      else $error("result word dropped in last stage");

   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      !s6_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe without a word behind it");

   a_range_gated : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.in_range |-> $past(s5_gate_ff && s5_along_ff, 2))
      else $error("in_range set although a gate failed");

endmodule

### design/line_segment_guidance_field_top.sv
// Top level of the line segment guidance field: register file, command port
// and the two pipeline halves. Uses lsg_pkg, lsg_front, lsg_back.
`timescale 1ns / 1ps

// Usage
//   Command channel: present a point on req_data and raise start. busy is
//   always low, so a word is taken on every cycle start is high; points may
//   be streamed back to back, one per clock.
//   Result channel: each point gives exactly one word on rsp_data, marked by
//   rsp_strobe for one cycle, after the register stages listed below. Words
//   leave in order of entry. The receiver must take them as they come.
//   Registers: csr_we with csr_index and csr_wdata writes one register per
//   edge. Write only while no point is in flight (until the last start has
//   given its word on rsp_data); indexes past the last register are ignored.
//   Throughput is one point per cycle; the datapath has seven register
//   stages (subtract, projection, A*D, rounding, gain, saturate and squares,
//   distance compare).
//   Reset (synchronous, high) restores the register defaults (direction +x,
//   gain 5.0, length and half width 1.0) and flushes every word in flight.

module line_segment_guidance_field_top import lsg_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  req_type                   req_data,
   output logic                      rsp_strobe,
   output rsp_type                   rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   front_type front_out;
   logic      req_fire;

   assign busy     = 1'b0;
   assign req_fire = start && !busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ORIGIN_X:   cfg_in.origin_x   = csr_wdata[COORD_BITS-1:0];
            CSR_ORIGIN_Y:   cfg_in.origin_y   = csr_wdata[COORD_BITS-1:0];
            CSR_DIR_X:      cfg_in.dir_x      = csr_wdata[DIR_BITS-1:0];
            CSR_DIR_Y:      cfg_in.dir_y      = csr_wdata[DIR_BITS-1:0];
            CSR_GAIN:       cfg_in.gain       = csr_wdata[GAIN_BITS-1:0];
            CSR_SEG_LENGTH: cfg_in.seg_length = csr_wdata[EXT_BITS-1:0];
            CSR_HALF_WIDTH: cfg_in.half_width = csr_wdata[EXT_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x   <= '0;
         cfg_ff.origin_y   <= '0;
         cfg_ff.dir_x      <= DIR_BITS'(1) << DIR_FRAC_BITS;
         cfg_ff.dir_y      <= '0;
         cfg_ff.gain       <= GAIN_BITS'(1280);
         cfg_ff.seg_length <= EXT_BITS'(256);
         cfg_ff.half_width <= EXT_BITS'(256);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lsg_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (req_fire),
      .in_data  (req_data),
      .out      (front_out)
   );

   lsg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in        (front_out),
      .rsp_valid (rsp_strobe),
      .rsp_data  (rsp_data)
   );

endmodule
